### hdl/srt_pkg.sv
package srt_pkg;

   // table geometry
   localparam int SLOTS   = 16;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);

   // field widths
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 16;
   localparam int SLOTNO_W = 4;
   localparam int PRICE_W  = 24;
   localparam int TOTAL_W  = 28;
   localparam int COUNT_W  = 5;

   // exact sum of all occupied prices, and the width of the divider step counter
   localparam int SUM_W  = PRICE_W + CNT_W;
   localparam int DIV_CW = $clog2(SUM_W + 1);

   // stream word widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 104;

   // saturation limits
   localparam logic [ID_W-1:0]    ID_MAX    = 16'hFFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 28'hFFFFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
   localparam logic [PRICE_W-1:0] PRICE_MAX = 24'hFFFFFF;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_TOTALS = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EXHAUSTED = 2'd3
   } status_type;

   // result word, first member in the highest bits
   typedef struct packed {
      logic [PRICE_W-1:0]  price_average;
      logic [COUNT_W-1:0]  occupied_count;
      logic [TOTAL_W-1:0]  price_total;
      logic [PRICE_W-1:0]  found_price;
      logic [SLOTNO_W-1:0] slot_index;
      logic [ID_W-1:0]     found_id;
      status_type          status;
   } result_type;

endpackage

### hdl/slot_record_table.sv
// Record table of SLOTS slots (16), each holding a valid bit, a 16-bit id and a 24-bit
// price. One command word in, one result word out. Every command sweeps the id/price
// memory through its single read port, one slot a cycle; totals on a non-empty table
// then runs the bit-serial divider that forms the average. Commands are handled one at
// a time; a new command is taken once the previous result is loaded into the output
// register. Valid bits sit in flip-flops and clear on reset, so no clearing pass is
// needed.
module slot_record_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata: record_id[15:0], price[39:16]
   input  logic [srt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: operation[1:0]
   input  logic [srt_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata: status[1:0], found_id[17:2], slot_index[21:18], found_price[45:22],
   // price_total[73:46], occupied_count[78:74], price_average[102:79], zero[103]
   output logic [srt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import srt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(SUM_W - 1);

   // control state
   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               issue_ff, issue_in;
   logic               chk_vld_ff, chk_vld_in;

   // command and sweep payload
   op_type             op_ff, op_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [PRICE_W-1:0] hit_price_ff, hit_price_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [DIV_CW-1:0]  div_step_ff, div_step_in;
   result_type         rsp_ff, rsp_in;

   // id/price memory
   logic [ID_W+PRICE_W-1:0] mem [SLOTS];
   logic [ID_W+PRICE_W-1:0] rd_data_ff;
   logic [ID_W+PRICE_W-1:0] mem_wd;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;

   logic               slot_v;
   logic [ID_W-1:0]    rd_id;
   logic [PRICE_W-1:0] rd_price;
   logic [ID_W-1:0]    id_plus;

   assign slot_v   = valid_ff[chk_idx_ff];
   assign rd_id    = rd_data_ff[ID_W+PRICE_W-1:PRICE_W];
   assign rd_price = rd_data_ff[PRICE_W-1:0];
   assign id_plus  = next_id_ff + 16'd1;
   assign mem_wd   = {id_plus, price_ff};
   assign rd_addr  = rd_idx_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // sequence one command: sweep, divide (totals only), deliver
   always_comb begin
      logic [CNT_W:0] trial;
      result_type     res;

      state_in     = state_ff;
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = rsp_valid_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      op_in        = op_ff;
      rid_in       = rid_ff;
      price_in     = price_ff;
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = rd_idx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_price_in = hit_price_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_step_in  = div_step_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      trial        = {rem_ff, quo_ff[SUM_W-1]};
      res          = '0;

      // drop the result word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = op_type'(req_tuser);
               rid_in       = req_tdata[ID_W-1:0];
               price_in     = req_tdata[ID_W+PRICE_W-1:ID_W];
               found_in     = 1'b0;
               hit_idx_in   = '0;
               hit_price_in = '0;
               sum_in       = '0;
               cnt_in       = '0;
               rd_idx_in    = '0;
               issue_in     = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one slot read a cycle
            if (issue_ff) begin
               chk_vld_in = 1'b1;
               if (rd_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            // check the slot whose word just came back
            if (chk_vld_ff) begin
               case (op_ff)
                  OP_ADD: begin
                     if (!found_ff && !slot_v) begin
                        found_in   = 1'b1;
                        hit_idx_in = chk_idx_ff;
                     end
                  end
                  OP_REMOVE, OP_LOOKUP: begin
                     if (!found_ff && slot_v && rd_id == rid_ff) begin
                        found_in     = 1'b1;
                        hit_idx_in   = chk_idx_ff;
                        hit_price_in = rd_price;
                     end
                  end
                  default: begin
                     if (slot_v) begin
                        sum_in = sum_ff + SUM_W'(rd_price);
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               endcase
            end
            // sweep drained
            if (!issue_ff && !chk_vld_ff) begin
               if (op_ff == OP_TOTALS && cnt_ff != '0) begin
                  quo_in      = sum_ff;
                  rem_in      = '0;
                  div_step_in = '0;
                  state_in    = ST_DIV;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            // one restoring step: sum / count
            if (trial >= {1'b0, cnt_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, cnt_ff});
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            div_step_in = div_step_ff + 1'b1;
            if (div_step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               case (op_ff)
                  OP_ADD: begin
                     if (!found_ff) begin
                        res.status = STATUS_FULL;
                     end else if (next_id_ff == ID_MAX) begin
                        res.status = STATUS_EXHAUSTED;
                     end else begin
                        res.status         = STATUS_OK;
                        res.found_id       = id_plus;
                        res.slot_index     = SLOTNO_W'(hit_idx_ff);
                        next_id_in         = id_plus;
                        mem_we             = 1'b1;
                        valid_in[hit_idx_ff] = 1'b1;
                     end
                  end
                  OP_REMOVE, OP_LOOKUP: begin
                     if (!found_ff) begin
                        res.status = STATUS_NOT_FOUND;
                     end else begin
                        res.status     = STATUS_OK;
                        res.found_id   = rid_ff;
                        res.slot_index = SLOTNO_W'(hit_idx_ff);
                        if (op_ff == OP_LOOKUP) begin
                           res.found_price = hit_price_ff;
                        end else begin
                           valid_in[hit_idx_ff] = 1'b0;
                        end
                     end
                  end
                  default: begin
                     res.status = STATUS_OK;
                     res.price_total = (64'(sum_ff) > 64'(TOTAL_MAX)) ?
                                       TOTAL_MAX : TOTAL_W'(sum_ff);
                     res.occupied_count = (32'(cnt_ff) > 32'(COUNT_MAX)) ?
                                          COUNT_MAX : COUNT_W'(cnt_ff);
                     if (cnt_ff != '0) begin
                        res.price_average = (64'(quo_ff) > 64'(PRICE_MAX)) ?
                                            PRICE_MAX : PRICE_W'(quo_ff);
                     end
                  end
               endcase
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rid_ff       <= rid_in;
      price_ff     <= price_in;
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_price_ff <= hit_price_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_step_ff  <= div_step_in;
      rsp_ff       <= rsp_in;
   end

   // id/price memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[hit_idx_ff] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // a new result word only comes out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside finish");

   // the divider never runs on an empty table
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff != '0))
      else $error("divide by zero count");

   // ids only step up by one
   a_id_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (next_id_ff == $past(next_id_ff) ||
                         next_id_ff == $past(next_id_ff) + 16'd1))
      else $error("id counter jumped");

   // a successful add marks its slot occupied
   a_add_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready) && op_ff == OP_ADD &&
       found_ff && next_id_ff != ID_MAX) |=> valid_ff[$past(hit_idx_ff)])
      else $error("added slot not marked valid");

endmodule

### bench/srt_checker.sv
module srt_checker
   import srt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // req_tdata: record_id[15:0], price[39:16]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: status[1:0], found_id[17:2], slot_index[21:18], found_price[45:22],
   // price_total[73:46], occupied_count[78:74], price_average[102:79], zero[103]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    error_count,
   output int                    pending,
   output int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 40;
   localparam int RESULT_W    = $bits(result_type);

   // mirror of the table contents and the id counter
   logic               slot_live   [SLOTS];
   logic [ID_W-1:0]    slot_owner  [SLOTS];
   logic [PRICE_W-1:0] slot_amount [SLOTS];
   logic [ID_W-1:0]    last_id;

   result_type expected_results[$];
   int         mismatches = 0;
   int         result_no  = 0;

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("[%0t] result %0d: %s", $time, result_no, what);
      end
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
      end
   endtask

   // apply one command to the mirror and return the result it must produce
   function automatic result_type apply_command(op_type op, logic [ID_W-1:0] rid,
                                                logic [PRICE_W-1:0] amount);
      result_type r;
      int         hit;
      longint     sum;
      longint     cnt;
      longint     avg;
      r   = '0;
      hit = -1;
      sum = 0;
      cnt = 0;
      avg = 0;
      case (op)
         OP_ADD: begin
            // scan downward so the lowest free slot wins
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_live[i]) hit = i;
            end
            if (hit < 0) begin
               r.status = STATUS_FULL;
            end else if (last_id == ID_MAX) begin
               r.status = STATUS_EXHAUSTED;
            end else begin
               last_id          = last_id + 1'b1;
               slot_live[hit]   = 1'b1;
               slot_owner[hit]  = last_id;
               slot_amount[hit] = amount;
               r.status         = STATUS_OK;
               r.found_id       = last_id;
               r.slot_index     = SLOTNO_W'(hit);
            end
         end
         OP_REMOVE, OP_LOOKUP: begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (slot_live[i] && slot_owner[i] == rid) hit = i;
            end
            if (hit < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               r.status     = STATUS_OK;
               r.found_id   = rid;
               r.slot_index = SLOTNO_W'(hit);
               if (op == OP_REMOVE) begin
                  slot_live[hit] = 1'b0;
               end else begin
                  r.found_price = slot_amount[hit];
               end
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i]) begin
                  sum += slot_amount[i];
                  cnt++;
               end
            end
            if (cnt != 0) avg = sum / cnt;
            r.status         = STATUS_OK;
            r.price_total    = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
            r.occupied_count = (cnt > COUNT_MAX) ? COUNT_MAX : COUNT_W'(cnt);
            r.price_average  = (avg > PRICE_MAX) ? PRICE_MAX : PRICE_W'(avg);
         end
      endcase
      return r;
   endfunction

   // compare one result word with the oldest prediction
   task automatic check_result(logic [RSP_DATA_W-1:0] word);
      result_type got;
      result_type want;
      got = result_type'(word[RESULT_W-1:0]);
      result_no++;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("word 0x%0h arrived with no prediction waiting", word));
      end else begin
         want = expected_results.pop_front();
         compare_field("status", got.status, want.status);
         compare_field("found_id", got.found_id, want.found_id);
         compare_field("slot_index", got.slot_index, want.slot_index);
         compare_field("found_price", got.found_price, want.found_price);
         compare_field("price_total", got.price_total, want.price_total);
         compare_field("occupied_count", got.occupied_count, want.occupied_count);
         compare_field("price_average", got.price_average, want.price_average);
         compare_field("pad bit", word[RSP_DATA_W-1], 1'b0);
      end
   endtask

   // watch both channels; publish counts with nonblocking updates
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
         end
         last_id = '0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_command(op_type'(req_tuser),
                                                     req_tdata[ID_W-1:0],
                                                     req_tdata[ID_W +: PRICE_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
         end
      end
      error_count <= mismatches;
      pending     <= expected_results.size();
      checked     <= result_no;
   end

endmodule

### bench/tb_slot_record_table.sv
module tb_slot_record_table;
   timeunit 1ns;
   timeprecision 1ps;

   import srt_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int FAST_ITEMS   = 20;
   localparam int DRAIN_LIMIT  = 4000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int error_count;
   int pending;
   int checked;

   // stimulus-side view of which ids are live
   logic [ID_W-1:0] live_ids[$];
   int              ids_issued = 0;
   int              sent_per_op[4] = '{0, 0, 0, 0};
   int              burst_left = 0;
   logic            fast_mode = 1'b0;
   logic [9:0]      stall_phase = '0;

   slot_record_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   srt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .pending     (pending),
      .checked     (checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hold off results: always ready, random, short periodic and long stalls in turn
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (fast_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         case (stall_phase[9:8])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 2) != 0);
            2'd2:    rsp_tready <= (stall_phase[2:0] != 3'd0);
            default: rsp_tready <= (stall_phase[4:0] < 5'd6);
         endcase
      end
   end

   // present one command word and hold it until taken
   task automatic send_word(op_type op, logic [ID_W-1:0] rid, logic [PRICE_W-1:0] amount);
      req_tuser  <= op;
      req_tdata  <= {amount, rid};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // send a command, track live ids, and idle between bursts when allowed
   task automatic issue(op_type op, logic [ID_W-1:0] rid, logic [PRICE_W-1:0] amount,
                        bit may_idle);
      int at;
      at = -1;
      send_word(op, rid, amount);
      sent_per_op[op]++;
      if (op == OP_ADD && live_ids.size() < SLOTS && ids_issued < ID_MAX) begin
         ids_issued++;
         live_ids.push_back(ID_W'(ids_issued));
      end else if (op == OP_REMOVE) begin
         foreach (live_ids[i]) begin
            if (live_ids[i] == rid) at = i;
         end
         if (at >= 0) live_ids.delete(at);
      end
      if (may_idle) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
   endtask

   // drop valid and wait for every outstanding result
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [PRICE_W-1:0] pick_price();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return PRICE_MAX;
         default: return PRICE_W'($urandom());
      endcase
   endfunction

   // mostly live ids, some stale or not yet issued, some anything
   function automatic logic [ID_W-1:0] pick_id();
      int roll;
      roll = $urandom_range(0, 9);
      if (live_ids.size() != 0 && roll < 7) begin
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      end
      if (roll < 9) return ID_W'(ids_issued + 1 - $urandom_range(0, 3));
      return ID_W'($urandom_range(0, 65535));
   endfunction

   initial begin
      int     roll;
      bit     fill_heavy;
      bit     gaps_on;
      op_type op;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, id zero, misses, slot reuse, full table
      issue(OP_TOTALS, '1, PRICE_MAX, 1'b0);
      issue(OP_LOOKUP, '0, '1, 1'b0);
      issue(OP_REMOVE, 16'd5, '0, 1'b0);
      issue(OP_ADD, '1, PRICE_MAX, 1'b0);
      issue(OP_ADD, '0, '0, 1'b0);
      issue(OP_LOOKUP, 16'd1, '0, 1'b0);
      issue(OP_REMOVE, 16'd1, '1, 1'b0);
      issue(OP_LOOKUP, 16'd1, '0, 1'b0);
      issue(OP_ADD, '0, PRICE_MAX, 1'b0);
      issue(OP_TOTALS, '0, '0, 1'b0);
      while (live_ids.size() < SLOTS) begin
         issue(OP_ADD, '0, PRICE_MAX, 1'b0);
      end
      issue(OP_ADD, '1, 24'h123456, 1'b0);
      issue(OP_TOTALS, '0, '0, 1'b0);
      wait_drained();

      // random: alternate fill-heavy and drain-heavy stretches
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         fill_heavy = ((n / 150) % 2) == 0;
         gaps_on    = ((n / 250) % 3) != 2;
         roll       = $urandom_range(0, 99);
         if (roll < (fill_heavy ? 40 : 20)) op = OP_ADD;
         else if (roll < 62) op = OP_REMOVE;
         else if (roll < 85) op = OP_LOOKUP;
         else op = OP_TOTALS;
         issue(op,
               (op == OP_REMOVE || op == OP_LOOKUP) ? pick_id() : ID_W'($urandom()),
               (op == OP_ADD) ? pick_price() : PRICE_W'($urandom()),
               gaps_on);
         if (n % 400 == 399) wait_drained();
      end
      wait_drained();

      // churn a full table at full rate: free the oldest id, add a new one
      fast_mode <= 1'b1;
      for (int n = 0; n < FAST_ITEMS; n++) begin
         if (live_ids.size() < SLOTS) begin
            issue(OP_ADD, ID_W'($urandom()), pick_price(), 1'b0);
         end else begin
            issue(OP_REMOVE, live_ids[0], PRICE_W'($urandom()), 1'b0);
         end
      end
      while (live_ids.size() < SLOTS) begin
         issue(OP_ADD, '0, pick_price(), 1'b0);
      end
      // full table refuses an add, then a freed slot is taken again
      issue(OP_ADD, '0, pick_price(), 1'b0);
      issue(OP_LOOKUP, ID_MAX, '0, 1'b0);
      issue(OP_REMOVE, live_ids[0], '0, 1'b0);
      issue(OP_ADD, '0, pick_price(), 1'b0);
      issue(OP_TOTALS, '0, '0, 1'b0);
      wait_drained();
      fast_mode <= 1'b0;

      // let any stray word show up
      repeat (64) @(posedge clock);
      if (pending != 0) $display("%0d predicted results never arrived", pending);
      $display("Covered %0d add, %0d remove, %0d lookup, %0d totals; %0d results compared.",
               sent_per_op[OP_ADD], sent_per_op[OP_REMOVE], sent_per_op[OP_LOOKUP],
               sent_per_op[OP_TOTALS], checked);
      $display("Ids issued up to %0d, with full-table and missing-id refusals.",
               ids_issued);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // end a hung run
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
hdl/srt_pkg.sv
hdl/slot_record_table.sv
bench/srt_checker.sv
bench/tb_slot_record_table.sv
